>>> design/vnod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnod_pkg
// Shared types, constants and step functions of the 2D vector normalize unit.
// ----------------------------------------------------------------------------
package vnod_pkg;

  // Number format.
  localparam int FRAC_BITS = 16;
  localparam int COMP_W    = 32;
  localparam int VAL_W     = 64;
  localparam int EPS_W     = 16;

  // Square root pipeline: 32 result bits, four per stage.
  localparam int SQRT_PER    = 4;
  localparam int SQRT_ITERS  = COMP_W;
  localparam int SQRT_STAGES = SQRT_ITERS / SQRT_PER;

  // Divider pipeline: the quotient never exceeds 2^FRAC_BITS.
  localparam int NUM_W      = COMP_W + FRAC_BITS;
  localparam int DIV_PER    = 4;
  localparam int DIV_STAGES = (FRAC_BITS + 1 + DIV_PER - 1) / DIV_PER;
  localparam int DIV_STEPS  = DIV_STAGES * DIV_PER;

  typedef enum logic [2:0] {
    OP_LENGTH = 3'd0,
    OP_UNIT   = 3'd1,
    OP_ORTHO  = 3'd2,
    OP_ROTATE = 3'd3,
    OP_DOT    = 3'd4
  } op_t;

  // Sideband data that travels with each word.
  typedef struct packed {
    op_t                       op;
    logic                      dir;
    logic signed [COMP_W-1:0]  ax;
    logic signed [COMP_W-1:0]  ay;
    logic signed [VAL_W-1:0]   val;
    logic                      basis;
  } side_t;

  typedef struct packed {
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [COMP_W-1:0]    r;
    logic [DIV_STEPS-1:0] q;
  } dv_t;

  // Rounded sqrt(1/2) in the vector format, worked out at elaboration.
  function automatic longint unsigned basis_calc();
    longint unsigned v;
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bt;
    v   = 64'd1 << (2 * FRAC_BITS - 1);
    rem = v;
    res = 0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    if (res * res + res < v) res = res + 1;
    return res;
  endfunction

  localparam logic [COMP_W-1:0] BASIS = COMP_W'(basis_calc());

  // One digit of the restoring square root; i counts from the top digit.
  function automatic sq_t sqrt_step(sq_t s, int i);
    sq_t              o;
    logic [VAL_W-1:0] bt;
    logic [VAL_W-1:0] trial;
    bt    = VAL_W'(1) << (62 - 2 * i);
    trial = s.res + bt;
    if (s.rem >= trial) begin
      o.rem = s.rem - trial;
      o.res = (s.res >> 1) + bt;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One bit of the restoring divider.
  function automatic dv_t div_step(dv_t d, logic nbit, logic [COMP_W-1:0] den);
    dv_t             o;
    logic [COMP_W:0] t;
    logic            ge;
    t  = {d.r, nbit};
    ge = (t >= {1'b0, den});
    if (ge) t = t - {1'b0, den};
    o.r = t[COMP_W-1:0];
    o.q = {d.q[DIV_STEPS-2:0], ge};
    return o;
  endfunction

endpackage

>>> design/vnod_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnod_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface vnod_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            operation;
  logic                                  direction;
  logic signed [vnod_pkg::COMP_W-1:0]    a_x;
  logic signed [vnod_pkg::COMP_W-1:0]    a_y;
  logic signed [vnod_pkg::COMP_W-1:0]    b_x;
  logic signed [vnod_pkg::COMP_W-1:0]    b_y;
  modport source (output valid, operation, direction, a_x, a_y, b_x, b_y, input ready);
  modport sink (input valid, operation, direction, a_x, a_y, b_x, b_y, output ready);
endinterface

interface vnod_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [vnod_pkg::COMP_W-1:0]    res_x;
  logic signed [vnod_pkg::COMP_W-1:0]    res_y;
  logic signed [vnod_pkg::VAL_W-1:0]     res_value;
  modport source (output valid, res_x, res_y, res_value, input ready);
  modport sink (input valid, res_x, res_y, res_value, output ready);
endinterface

>>> design/vnod_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnod_sqrt
// Pipelined integer square root of a 64-bit radicand, four digits per stage.
// ----------------------------------------------------------------------------
module vnod_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [vnod_pkg::VAL_W-1:0]       in_rad,
  input  vnod_pkg::side_t                  in_side,
  output logic                             out_vld,
  output logic [vnod_pkg::COMP_W-1:0]      out_root,
  output vnod_pkg::side_t                  out_side
);

  logic              vld_r  [vnod_pkg::SQRT_STAGES];
  vnod_pkg::sq_t     sq_r   [vnod_pkg::SQRT_STAGES];
  vnod_pkg::side_t   side_r [vnod_pkg::SQRT_STAGES];

  for (genvar g = 0; g < vnod_pkg::SQRT_STAGES; g++) begin : g_stage
    logic            src_vld;
    vnod_pkg::sq_t   src_sq;
    vnod_pkg::side_t src_side;
    vnod_pkg::sq_t   sq_nxt;

    // Pick the stage input.
    if (g == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_sq   = '{rem: in_rad, res: '0};
      assign src_side = in_side;
    end else begin : g_rest
      assign src_vld  = vld_r[g-1];
      assign src_sq   = sq_r[g-1];
      assign src_side = side_r[g-1];
    end

    // Four digits of the root in this stage.
    always_comb begin
      sq_nxt = src_sq;
      for (int k = 0; k < vnod_pkg::SQRT_PER; k++) begin
        sq_nxt = vnod_pkg::sqrt_step(sq_nxt, g * vnod_pkg::SQRT_PER + k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[g]   <= sq_nxt;
        side_r[g] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[vnod_pkg::SQRT_STAGES-1];
  assign out_root = sq_r[vnod_pkg::SQRT_STAGES-1].res[vnod_pkg::COMP_W-1:0];
  assign out_side = side_r[vnod_pkg::SQRT_STAGES-1];

endmodule

>>> design/vnod_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnod_div
// Two pipelined restoring dividers that scale both components by the length.
// ----------------------------------------------------------------------------
module vnod_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [vnod_pkg::NUM_W-1:0]       in_num_x,
  input  logic [vnod_pkg::NUM_W-1:0]       in_num_y,
  input  logic [vnod_pkg::COMP_W-1:0]      in_den,
  input  vnod_pkg::side_t                  in_side,
  output logic                             out_vld,
  output logic [vnod_pkg::COMP_W-1:0]      out_q_x,
  output logic [vnod_pkg::COMP_W-1:0]      out_q_y,
  output vnod_pkg::side_t                  out_side
);

  localparam int LAST = vnod_pkg::DIV_STAGES - 1;

  logic                          vld_r  [vnod_pkg::DIV_STAGES];
  logic [vnod_pkg::NUM_W-1:0]    nx_r   [vnod_pkg::DIV_STAGES];
  logic [vnod_pkg::NUM_W-1:0]    ny_r   [vnod_pkg::DIV_STAGES];
  logic [vnod_pkg::COMP_W-1:0]   den_r  [vnod_pkg::DIV_STAGES];
  vnod_pkg::dv_t                 dx_r   [vnod_pkg::DIV_STAGES];
  vnod_pkg::dv_t                 dy_r   [vnod_pkg::DIV_STAGES];
  vnod_pkg::side_t               side_r [vnod_pkg::DIV_STAGES];

  for (genvar g = 0; g < vnod_pkg::DIV_STAGES; g++) begin : g_stage
    logic                        src_vld;
    logic [vnod_pkg::NUM_W-1:0]  src_nx;
    logic [vnod_pkg::NUM_W-1:0]  src_ny;
    logic [vnod_pkg::COMP_W-1:0] src_den;
    vnod_pkg::dv_t               src_dx;
    vnod_pkg::dv_t               src_dy;
    vnod_pkg::side_t             src_side;
    vnod_pkg::dv_t               dx_nxt;
    vnod_pkg::dv_t               dy_nxt;

    // The first stage starts from the top part of the numerator, which is
    // below the divisor because the quotient fits in the step count.
    if (g == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_nx   = in_num_x;
      assign src_ny   = in_num_y;
      assign src_den  = in_den;
      assign src_dx   = '{r: vnod_pkg::COMP_W'(in_num_x >> vnod_pkg::DIV_STEPS), q: '0};
      assign src_dy   = '{r: vnod_pkg::COMP_W'(in_num_y >> vnod_pkg::DIV_STEPS), q: '0};
      assign src_side = in_side;
    end else begin : g_rest
      assign src_vld  = vld_r[g-1];
      assign src_nx   = nx_r[g-1];
      assign src_ny   = ny_r[g-1];
      assign src_den  = den_r[g-1];
      assign src_dx   = dx_r[g-1];
      assign src_dy   = dy_r[g-1];
      assign src_side = side_r[g-1];
    end

    // Four quotient bits per stage and component.
    always_comb begin
      dx_nxt = src_dx;
      dy_nxt = src_dy;
      for (int k = 0; k < vnod_pkg::DIV_PER; k++) begin
        dx_nxt = vnod_pkg::div_step(dx_nxt,
                   src_nx[vnod_pkg::DIV_STEPS-1-(g*vnod_pkg::DIV_PER+k)], src_den);
        dy_nxt = vnod_pkg::div_step(dy_nxt,
                   src_ny[vnod_pkg::DIV_STEPS-1-(g*vnod_pkg::DIV_PER+k)], src_den);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[g]   <= src_nx;
        ny_r[g]   <= src_ny;
        den_r[g]  <= src_den;
        dx_r[g]   <= dx_nxt;
        dy_r[g]   <= dy_nxt;
        side_r[g] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[LAST];
  assign out_q_x  = vnod_pkg::COMP_W'(dx_r[LAST].q);
  assign out_q_y  = vnod_pkg::COMP_W'(dy_r[LAST].q);
  assign out_side = side_r[LAST];

endmodule

>>> design/vector2d_normalize_ortho_dot_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector2d_normalize_ortho_dot_top
// 2D vector unit: length, unit, orthogonal, rotate and dot product.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, 8 square root stages, 5 divider stages and
//   1 output register between input word and result word.
// Throughput: one word per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken.
// Reset: synchronous, active low; clears all valid bits and sets zero_epsilon
//   to 1. No clearing pass.
module vector2d_normalize_ortho_dot_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vnod_pkg::EPS_W-1:0]      cfg_data,
  vnod_in_if.sink                         in_ch,
  vnod_out_if.source                      out_ch
);

  localparam int CW = vnod_pkg::COMP_W;
  localparam int VW = vnod_pkg::VAL_W;
  localparam int FB = vnod_pkg::FRAC_BITS;

  logic                      en;
  logic [vnod_pkg::EPS_W-1:0] eps_r;

  // Epsilon register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= vnod_pkg::EPS_W'(1);
    end else if (cfg_we) begin
      eps_r <= cfg_data;
    end
  end

  // Pipeline advances whenever the output register can move.
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: magnitudes and products.
  logic [CW-1:0]        abs_ax;
  logic [CW-1:0]        abs_ay;
  vnod_pkg::side_t      side_in;
  logic                 s1_vld_r;
  vnod_pkg::side_t      s1_side_r;
  logic [VW-1:0]        s1_sqx_r;
  logic [VW-1:0]        s1_sqy_r;
  logic signed [VW-1:0] s1_p1_r;
  logic signed [VW-1:0] s1_p2_r;

  always_comb begin
    abs_ax        = in_ch.a_x[CW-1] ? CW'(-in_ch.a_x) : in_ch.a_x;
    abs_ay        = in_ch.a_y[CW-1] ? CW'(-in_ch.a_y) : in_ch.a_y;
    side_in.op    = vnod_pkg::op_t'(in_ch.operation);
    side_in.dir   = in_ch.direction;
    side_in.ax    = in_ch.a_x;
    side_in.ay    = in_ch.a_y;
    side_in.val   = '0;
    side_in.basis = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= side_in;
      s1_sqx_r  <= VW'(abs_ax) * VW'(abs_ax);
      s1_sqy_r  <= VW'(abs_ay) * VW'(abs_ay);
      s1_p1_r   <= VW'(in_ch.a_x) * VW'(in_ch.b_x);
      s1_p2_r   <= VW'(in_ch.a_y) * VW'(in_ch.b_y);
    end
  end

  // Stage 2: sum of squares and saturated dot product.
  logic [VW:0]     dot_sum;
  vnod_pkg::side_t side_s2;
  logic            s2_vld_r;
  vnod_pkg::side_t s2_side_r;
  logic [VW-1:0]   s2_rad_r;

  always_comb begin
    dot_sum = {s1_p1_r[VW-1], s1_p1_r} + {s1_p2_r[VW-1], s1_p2_r};
    side_s2 = s1_side_r;
    if (!dot_sum[VW] && dot_sum[VW-1]) begin
      side_s2.val = {1'b0, {(VW-1){1'b1}}};
    end else begin
      side_s2.val = dot_sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r <= side_s2;
      s2_rad_r  <= s1_sqx_r + s1_sqy_r;
    end
  end

  // Square root pipeline.
  logic            sq_vld;
  logic [CW-1:0]   sq_root;
  vnod_pkg::side_t sq_side;

  vnod_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_rad   (s2_rad_r),
    .in_side  (s2_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Zero test against epsilon and numerators for the divider.
  vnod_pkg::side_t            side_dv;
  logic [CW-1:0]              len_ax;
  logic [CW-1:0]              len_ay;
  logic [vnod_pkg::NUM_W-1:0] num_x;
  logic [vnod_pkg::NUM_W-1:0] num_y;

  always_comb begin
    side_dv       = sq_side;
    side_dv.basis = (sq_root <= CW'(eps_r));
    if (sq_side.op == vnod_pkg::OP_LENGTH) begin
      side_dv.val = VW'(sq_root);
    end
    len_ax = sq_side.ax[CW-1] ? CW'(-sq_side.ax) : sq_side.ax;
    len_ay = sq_side.ay[CW-1] ? CW'(-sq_side.ay) : sq_side.ay;
    num_x  = {len_ax, {FB{1'b0}}};
    num_y  = {len_ay, {FB{1'b0}}};
  end

  // Divider pipeline.
  logic            dv_vld;
  logic [CW-1:0]   q_x;
  logic [CW-1:0]   q_y;
  vnod_pkg::side_t dv_side;

  vnod_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_num_x (num_x),
    .in_num_y (num_y),
    .in_den   (sq_root),
    .in_side  (side_dv),
    .out_vld  (dv_vld),
    .out_q_x  (q_x),
    .out_q_y  (q_y),
    .out_side (dv_side)
  );

  // Result selection.
  logic signed [CW-1:0] ux;
  logic signed [CW-1:0] uy;
  logic signed [CW-1:0] rx_nxt;
  logic signed [CW-1:0] ry_nxt;
  logic signed [VW-1:0] val_nxt;
  logic signed [CW-1:0] neg_ax;
  logic signed [CW-1:0] neg_ay;
  localparam logic signed [CW-1:0] MIN32 = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] MAX32 = {1'b0, {(CW-1){1'b1}}};

  always_comb begin
    if (dv_side.basis) begin
      ux = vnod_pkg::BASIS;
      uy = vnod_pkg::BASIS;
    end else begin
      ux = dv_side.ax[CW-1] ? CW'(-q_x) : q_x;
      uy = dv_side.ay[CW-1] ? CW'(-q_y) : q_y;
    end
    neg_ax  = (dv_side.ax == MIN32) ? MAX32 : CW'(-dv_side.ax);
    neg_ay  = (dv_side.ay == MIN32) ? MAX32 : CW'(-dv_side.ay);
    rx_nxt  = '0;
    ry_nxt  = '0;
    val_nxt = '0;
    case (dv_side.op)
      vnod_pkg::OP_LENGTH: val_nxt = dv_side.val;
      vnod_pkg::OP_UNIT: begin
        rx_nxt = ux;
        ry_nxt = uy;
      end
      vnod_pkg::OP_ORTHO: begin
        rx_nxt = dv_side.dir ? CW'(-uy) : uy;
        ry_nxt = dv_side.dir ? ux : CW'(-ux);
      end
      vnod_pkg::OP_ROTATE: begin
        rx_nxt = dv_side.dir ? neg_ay : dv_side.ay;
        ry_nxt = dv_side.dir ? dv_side.ax : neg_ax;
      end
      vnod_pkg::OP_DOT: val_nxt = dv_side.val;
      default: begin
        rx_nxt  = '0;
        ry_nxt  = '0;
        val_nxt = '0;
      end
    endcase
  end

  // Output register.
  logic signed [CW-1:0] res_x_r;
  logic signed [CW-1:0] res_y_r;
  logic signed [VW-1:0] res_val_r;
  vnod_pkg::op_t        out_op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r   <= rx_nxt;
      res_y_r   <= ry_nxt;
      res_val_r <= val_nxt;
      out_op_r  <= dv_side.op;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.res_x     = res_x_r;
  assign out_ch.res_y     = res_y_r;
  assign out_ch.res_value = res_val_r;

  // Reset puts epsilon back to one.
  a_eps_reset: assert property (@(posedge clk) !rst_n |=> eps_r == vnod_pkg::EPS_W'(1))
    else $error("zero_epsilon not restored by reset");

  // A stall freezes the front of the pipeline.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s1_vld_r) && $stable(s2_vld_r))
    else $error("pipeline moved during stall");

  // Scalar operations leave the vector fields at zero.
  a_scalar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_op_r == vnod_pkg::OP_LENGTH || out_op_r == vnod_pkg::OP_DOT)
    |-> res_x_r == '0 && res_y_r == '0)
    else $error("scalar result with nonzero vector");

endmodule

>>> verif/vector2d_normalize_ortho_dot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector2d_normalize_ortho_dot_checker
// Watches the input, result and configuration ports of the 2D vector unit.
// It predicts the result of every accepted input word and compares it, field
// by field, with the result words in the order they arrive.
// ----------------------------------------------------------------------------
module vector2d_normalize_ortho_dot_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [vnod_pkg::EPS_W-1:0] cfg_data,
  vnod_in_if                         in_mon,
  vnod_out_if                        out_mon,
  output int                         fail_count,
  output int                         pending
);

  typedef struct {
    logic signed [vnod_pkg::COMP_W-1:0] x;
    logic signed [vnod_pkg::COMP_W-1:0] y;
    logic signed [vnod_pkg::VAL_W-1:0]  v;
  } vec_result_t;

  vec_result_t                        expected_q[$];
  logic [vnod_pkg::EPS_W-1:0]         epsilon;
  logic signed [vnod_pkg::COMP_W-1:0] half_root;

  // Integer square root, rounded down.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magnitude(logic signed [vnod_pkg::COMP_W-1:0] c);
    longint signed w;
    w = c;
    return (w < 0) ? longint'(-w) : longint'(w);
  endfunction

  function automatic longint unsigned vec_length(logic signed [vnod_pkg::COMP_W-1:0] x,
                                                 logic signed [vnod_pkg::COMP_W-1:0] y);
    longint unsigned mx;
    longint unsigned my;
    mx = magnitude(x);
    my = magnitude(y);
    return int_sqrt(mx * mx + my * my);
  endfunction

  // Unit vector, with the basis vector when the length counts as zero.
  function automatic void unit_of(logic signed [vnod_pkg::COMP_W-1:0] x,
                                  logic signed [vnod_pkg::COMP_W-1:0] y,
                                  output logic signed [vnod_pkg::COMP_W-1:0] ux,
                                  output logic signed [vnod_pkg::COMP_W-1:0] uy);
    longint unsigned len;
    longint unsigned qx;
    longint unsigned qy;
    len = vec_length(x, y);
    if (len <= epsilon) begin
      ux = half_root;
      uy = half_root;
    end else begin
      qx = (magnitude(x) << vnod_pkg::FRAC_BITS) / len;
      qy = (magnitude(y) << vnod_pkg::FRAC_BITS) / len;
      ux = (x < 0) ? -vnod_pkg::COMP_W'(qx) : vnod_pkg::COMP_W'(qx);
      uy = (y < 0) ? -vnod_pkg::COMP_W'(qy) : vnod_pkg::COMP_W'(qy);
    end
  endfunction

  function automatic logic signed [vnod_pkg::COMP_W-1:0] negate_sat(
      logic signed [vnod_pkg::COMP_W-1:0] v);
    logic signed [vnod_pkg::COMP_W-1:0] most_neg;
    most_neg = {1'b1, {(vnod_pkg::COMP_W-1){1'b0}}};
    return (v == most_neg) ? ~most_neg : -v;
  endfunction

  function automatic vec_result_t vector_op(logic [2:0] op, logic dir,
                                            logic signed [vnod_pkg::COMP_W-1:0] ax,
                                            logic signed [vnod_pkg::COMP_W-1:0] ay,
                                            logic signed [vnod_pkg::COMP_W-1:0] bx,
                                            logic signed [vnod_pkg::COMP_W-1:0] by);
    vec_result_t                        r;
    logic signed [vnod_pkg::COMP_W-1:0] ux;
    logic signed [vnod_pkg::COMP_W-1:0] uy;
    logic signed [vnod_pkg::VAL_W:0]    sum;
    r.x = '0;
    r.y = '0;
    r.v = '0;
    case (op)
      vnod_pkg::OP_LENGTH: begin
        r.v = vec_length(ax, ay);
      end
      vnod_pkg::OP_UNIT: begin
        unit_of(ax, ay, r.x, r.y);
      end
      vnod_pkg::OP_ORTHO: begin
        unit_of(ax, ay, ux, uy);
        r.x = dir ? -uy : uy;
        r.y = dir ? ux : -ux;
      end
      vnod_pkg::OP_ROTATE: begin
        r.x = dir ? negate_sat(ay) : ay;
        r.y = dir ? ax : negate_sat(ax);
      end
      vnod_pkg::OP_DOT: begin
        // Only both products at their most positive can leave the range.
        sum = $signed(vnod_pkg::VAL_W'(ax) * vnod_pkg::VAL_W'(bx))
            + $signed(vnod_pkg::VAL_W'(ay) * vnod_pkg::VAL_W'(by));
        r.v = (sum > $signed({2'b00, {(vnod_pkg::VAL_W-1){1'b1}}}))
            ? {1'b0, {(vnod_pkg::VAL_W-1){1'b1}}} : sum[vnod_pkg::VAL_W-1:0];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    epsilon    = 1;
    half_root  = vnod_pkg::COMP_W'(int_sqrt(64'd1 << (2 * vnod_pkg::FRAC_BITS - 1)));
    if ({32'd0, half_root} * half_root + half_root
        < (64'd1 << (2 * vnod_pkg::FRAC_BITS - 1)))
      half_root = half_root + 1;
  end

  // Track the threshold and predict each accepted input word.
  always @(posedge clk) begin
    if (!rst_n) begin
      epsilon = 1;
    end else begin
      if (cfg_we) epsilon = cfg_data;
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(vector_op(in_mon.operation, in_mon.direction,
                                       in_mon.a_x, in_mon.a_y, in_mon.b_x, in_mon.b_y));
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    vec_result_t e;
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word x=%h y=%h value=%h", $time,
                 out_mon.res_x, out_mon.res_y, out_mon.res_value);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_mon.res_x !== e.x) begin
          $display("%0t: res_x expected %h actual %h", $time, e.x, out_mon.res_x);
          fail_count++;
        end
        if (out_mon.res_y !== e.y) begin
          $display("%0t: res_y expected %h actual %h", $time, e.y, out_mon.res_y);
          fail_count++;
        end
        if (out_mon.res_value !== e.v) begin
          $display("%0t: res_value expected %h actual %h", $time, e.v, out_mon.res_value);
          fail_count++;
        end
      end
    end
    #0 pending = expected_q.size();
  end

endmodule

>>> verif/vector2d_normalize_ortho_dot_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector2d_normalize_ortho_dot_top_tb
// Drives directed and random vector words into the 2D vector unit under
// several zero thresholds, with random gaps on both sides, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module vector2d_normalize_ortho_dot_top_tb;

  localparam logic signed [vnod_pkg::COMP_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [vnod_pkg::COMP_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [vnod_pkg::COMP_W-1:0] ONE      = 32'sh0001_0000;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [vnod_pkg::EPS_W-1:0] cfg_data;
  logic                       steady;
  int                         fail_count;
  int                         pending;

  vnod_in_if  in_ch ();
  vnod_out_if out_ch ();

  vector2d_normalize_ortho_dot_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  vector2d_normalize_ortho_dot_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Outside steady stretches, the result side stalls about 18 percent of the time.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 18);
  end

  // Offer one word and hold it until it is taken; then maybe leave a gap.
  task automatic send_word(logic [2:0] op, logic dir,
                           logic signed [vnod_pkg::COMP_W-1:0] ax,
                           logic signed [vnod_pkg::COMP_W-1:0] ay,
                           logic signed [vnod_pkg::COMP_W-1:0] bx,
                           logic signed [vnod_pkg::COMP_W-1:0] by);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.direction <= dir;
    in_ch.a_x       <= ax;
    in_ch.a_y       <= ay;
    in_ch.b_x       <= bx;
    in_ch.b_y       <= by;
    do @(posedge clk); while (!in_ch.ready);
    if (!steady && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Change the threshold once every result has come back.
  task automatic set_epsilon(logic [vnod_pkg::EPS_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [vnod_pkg::COMP_W-1:0] rand_comp();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2: return $signed($urandom_range(16)) - 8;
      3, 4, 5: return $signed($urandom());
      default: return $signed($urandom()) >>> $urandom_range(24, 4);
    endcase
  endfunction

  task automatic random_words(int count, int calm_from, int calm_to);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      steady = (i >= calm_from) && (i < calm_to);
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_word(op, 1'($urandom()), rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    steady = 1'b0;
  endtask

  initial begin
    #(4_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int guard;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    steady          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.direction = 1'b0;
    in_ch.a_x       = '0;
    in_ch.a_y       = '0;
    in_ch.b_x       = '0;
    in_ch.b_y       = '0;
    out_ch.ready    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset threshold.
    send_word(vnod_pkg::OP_LENGTH, 0, 3 * ONE, 4 * ONE, 0, 0);
    send_word(vnod_pkg::OP_LENGTH, 0, MOST_NEG, MOST_NEG, 0, 0);
    send_word(vnod_pkg::OP_LENGTH, 1, MOST_POS, MOST_NEG, 0, 0);
    send_word(vnod_pkg::OP_UNIT, 0, 3 * ONE, -4 * ONE, 0, 0);
    send_word(vnod_pkg::OP_UNIT, 0, 0, 0, 0, 0);
    send_word(vnod_pkg::OP_UNIT, 1, 1, 1, 0, 0);
    send_word(vnod_pkg::OP_UNIT, 0, 2, 0, 0, 0);
    send_word(vnod_pkg::OP_UNIT, 0, MOST_NEG, MOST_POS, 0, 0);
    send_word(vnod_pkg::OP_ORTHO, 0, ONE, 2 * ONE, 0, 0);
    send_word(vnod_pkg::OP_ORTHO, 1, ONE, 2 * ONE, 0, 0);
    send_word(vnod_pkg::OP_ORTHO, 1, 0, 0, 0, 0);
    send_word(vnod_pkg::OP_ROTATE, 0, MOST_NEG, MOST_NEG, 0, 0);
    send_word(vnod_pkg::OP_ROTATE, 1, MOST_NEG, MOST_NEG, 0, 0);
    send_word(vnod_pkg::OP_ROTATE, 0, 5, -7, 0, 0);
    send_word(vnod_pkg::OP_DOT, 0, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
    send_word(vnod_pkg::OP_DOT, 0, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
    send_word(vnod_pkg::OP_DOT, 0, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG);
    send_word(vnod_pkg::OP_DOT, 1, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS);
    send_word(3'd5, 1, -1, -1, -1, -1);
    send_word(3'd6, 0, MOST_POS, 1, 1, 1);
    send_word(3'd7, 1, MOST_NEG, 2, 3, 4);
    random_words(480, 200, 320);

    // Threshold zero: only the null vector falls back to the basis.
    set_epsilon(0);
    send_word(vnod_pkg::OP_UNIT, 0, 0, 0, 0, 0);
    send_word(vnod_pkg::OP_ORTHO, 1, 1, 0, 0, 0);
    random_words(450, 100, 180);

    // Largest threshold: every length up to just under one counts as zero.
    set_epsilon(16'hFFFF);
    send_word(vnod_pkg::OP_UNIT, 0, 32'sh0000_FFFF, 0, 0, 0);
    send_word(vnod_pkg::OP_UNIT, 0, ONE, 0, 0, 0);
    random_words(450, 250, 330);

    set_epsilon(vnod_pkg::EPS_W'($urandom()));
    random_words(300, 0, 0);
    set_epsilon(16'd1);
    random_words(240, 60, 120);

    // Drain, then allow for the pipeline latency.
    in_ch.valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/vnod_pkg.sv
design/vnod_if.sv
design/vnod_sqrt.sv
design/vnod_div.sv
design/vector2d_normalize_ortho_dot_top.sv
verif/vector2d_normalize_ortho_dot_checker.sv
verif/vector2d_normalize_ortho_dot_top_tb.sv
